/* rtl/btlbp_pkg.sv */
package btlbp_pkg;

    localparam logic CMD_PREDICT = 1'b0;
    localparam logic CMD_UPDATE  = 1'b1;

    localparam int CTR_W = 2;

    localparam logic [CTR_W-1:0] CTR_MIN    = 2'd0;
    localparam logic [CTR_W-1:0] CTR_MAX    = 2'd3;
    localparam logic [CTR_W-1:0] CTR_STRONG = 2'd2;

    // Distance to the sequential instruction: any other next PC counts as taken
    localparam logic [31:0] FALL_THROUGH = 32'd4;

    // Training request broadcast to every entry
    typedef struct packed {
        logic        alloc;
        logic        taken;
        logic [31:0] tag;
        logic [31:0] target;
    } upd_t;

    // Lookup status of one entry
    typedef struct packed {
        logic hit;
        logic confident;
    } entry_status_t;

endpackage

/* rtl/btlbp_req_if.sv */
interface btlbp_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] pc;
    logic [31:0] pc_next;
    logic        is_branch;

    modport source (
        output valid,
        output cmd,
        output pc,
        output pc_next,
        output is_branch,
        input  ready
    );

    modport sink (
        input  valid,
        input  cmd,
        input  pc,
        input  pc_next,
        input  is_branch,
        output ready
    );
endinterface

/* rtl/btlbp_resp_if.sv */
interface btlbp_resp_if;
    logic        valid;
    logic        ready;
    logic [31:0] pred_target;
    logic        pred_taken;

    modport source (
        output valid,
        output pred_target,
        output pred_taken,
        input  ready
    );

    modport sink (
        input  valid,
        input  pred_target,
        input  pred_taken,
        output ready
    );
endinterface

/* rtl/btlbp_entry.sv */
module btlbp_entry #(
    parameter int HISTORY_BITS = 2
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [31:0]              lookup_pc,
    input  logic                     sel,
    input  btlbp_pkg::upd_t          upd,
    output btlbp_pkg::entry_status_t status,
    output logic [31:0]              target
);

    localparam int PATTERNS = 1 << HISTORY_BITS;
    localparam int CTRS_W   = PATTERNS * btlbp_pkg::CTR_W;

    logic                          valid_reg;
    logic [31:0]                   tag_reg;
    logic [31:0]                   target_reg;
    logic [HISTORY_BITS-1:0]       hist_reg;
    logic [HISTORY_BITS-1:0]       hist_next;
    logic [CTRS_W-1:0]             ctrs_reg;
    logic [CTRS_W-1:0]             ctrs_next;

    logic [HISTORY_BITS-1:0]       hist_cur;
    logic [CTRS_W-1:0]             ctrs_cur;
    logic [btlbp_pkg::CTR_W-1:0]   ctr_old;
    logic [btlbp_pkg::CTR_W-1:0]   ctr_new;
    logic [HISTORY_BITS:0]         hist_shift;
    logic [btlbp_pkg::CTR_W-1:0]   ctr_look;

    // Lookup
    assign ctr_look         = ctrs_reg[hist_reg * btlbp_pkg::CTR_W +: btlbp_pkg::CTR_W];
    assign status.hit       = valid_reg && (tag_reg == lookup_pc);
    assign status.confident = ctr_look >= btlbp_pkg::CTR_STRONG;
    assign target           = target_reg;

    // Training: allocation starts from cleared history and counters
    always_comb
    begin
        hist_cur = upd.alloc ? '0 : hist_reg;
        ctrs_cur = upd.alloc ? '0 : ctrs_reg;
        ctr_old  = ctrs_cur[hist_cur * btlbp_pkg::CTR_W +: btlbp_pkg::CTR_W];
        if (upd.taken)
        begin
            ctr_new = (ctr_old == btlbp_pkg::CTR_MAX) ? ctr_old
                                                      : ctr_old + 1'b1;
        end
        else
        begin
            ctr_new = (ctr_old == btlbp_pkg::CTR_MIN) ? ctr_old
                                                      : ctr_old - 1'b1;
        end
        ctrs_next = ctrs_cur;
        ctrs_next[hist_cur * btlbp_pkg::CTR_W +: btlbp_pkg::CTR_W] = ctr_new;
        hist_shift = {hist_cur, upd.taken};
        hist_next  = hist_shift[HISTORY_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sel && upd.alloc)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel)
        begin
            if (upd.alloc)
            begin
                tag_reg <= upd.tag;
            end
            target_reg <= upd.target;
            hist_reg   <= hist_next;
            ctrs_reg   <= ctrs_next;
        end
    end

endmodule

/* rtl/bounded_two_level_branch_predictor.sv */
// Fully associative two-level local-history branch predictor. A request with
// cmd = 0 asks for a prediction for pc and yields one response (pred_target,
// zero meaning not taken, and pred_taken); a request with cmd = 1 trains the
// table from an executed instruction and yields no response. One request is
// accepted every cycle while nothing stalls: it is held in an input register,
// compared against all ENTRIES tags at once and answered into the response
// register when it advances, while the same edge writes any training into the
// table, so each request sees every earlier one's effect. A stalled response
// holds back a waiting prediction and all behind it, not a waiting update.
// Training misses allocate round-robin, evicting whatever the pointer names.
module bounded_two_level_branch_predictor #(
    parameter int ENTRIES      = 128,
    parameter int HISTORY_BITS = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    btlbp_req_if.sink  req,
    btlbp_resp_if.source resp
);

    localparam int VP_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [VP_W-1:0] VP_LAST = VP_W'(ENTRIES - 1);

    // Input register
    logic        in_valid_reg;
    logic        in_valid_next;
    logic        cmd_reg;
    logic [31:0] pc_reg;
    logic [31:0] pc_next_reg;
    logic        brjmp_reg;

    // Response register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] target_reg;
    logic        taken_reg;

    logic [VP_W-1:0] vp_reg;
    logic [VP_W-1:0] vp_next;

    logic                     req_fire;
    logic                     out_free;
    logic                     advance;
    logic                     do_train;
    logic                     any_hit;
    logic [31:0]              lookup_target;
    logic [ENTRIES-1:0]       hit_vec;
    logic [ENTRIES-1:0]       sel_vec;
    btlbp_pkg::upd_t          upd;
    btlbp_pkg::entry_status_t status [ENTRIES];
    logic [31:0]              entry_target [ENTRIES];

    // Handshake: advance an update at once, a prediction when the response slot frees
    assign out_free  = !out_valid_reg || resp.ready;
    assign advance   = in_valid_reg && ((cmd_reg == btlbp_pkg::CMD_UPDATE) || out_free);
    assign req.ready = !in_valid_reg || advance;
    assign req_fire  = req.valid && req.ready;
    assign do_train  = advance && (cmd_reg == btlbp_pkg::CMD_UPDATE) && brjmp_reg;

    always_comb
    begin
        if (req_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_comb
    begin
        if (advance && (cmd_reg == btlbp_pkg::CMD_PREDICT))
        begin
            out_valid_next = 1'b1;
        end
        else if (resp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Table: one cell per entry, each comparing its own tag
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_entry
        btlbp_entry #(
            .HISTORY_BITS (HISTORY_BITS)
        ) u_entry (
            .clk       (clk),
            .rst_n     (rst_n),
            .lookup_pc (pc_reg),
            .sel       (sel_vec[g]),
            .upd       (upd),
            .status    (status[g]),
            .target    (entry_target[g])
        );
        assign hit_vec[g] = status[g].hit;
    end

    // Tags are unique, so at most one entry hits: merge with an AND-OR select
    always_comb
    begin
        lookup_target = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (status[i].hit && status[i].confident)
            begin
                lookup_target = lookup_target | entry_target[i];
            end
        end
    end

    assign any_hit = |hit_vec;

    // Train the hitting entry, or allocate the one under the victim pointer
    always_comb
    begin
        upd.alloc  = !any_hit;
        upd.taken  = (pc_next_reg - pc_reg) != btlbp_pkg::FALL_THROUGH;
        upd.tag    = pc_reg;
        upd.target = pc_next_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            sel_vec[i] = do_train && (any_hit ? hit_vec[i] : (vp_reg == VP_W'(i)));
        end
    end

    // Advance the victim pointer on each allocation, wrapping after the last entry
    always_comb
    begin
        vp_next = vp_reg;
        if (do_train && !any_hit)
        begin
            vp_next = (vp_reg == VP_LAST) ? '0 : vp_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            vp_reg        <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            vp_reg        <= vp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cmd_reg     <= req.cmd;
            pc_reg      <= req.pc;
            pc_next_reg <= req.pc_next;
            brjmp_reg   <= req.is_branch;
        end
        if (advance && (cmd_reg == btlbp_pkg::CMD_PREDICT))
        begin
            target_reg <= lookup_target;
            taken_reg  <= lookup_target != '0;
        end
    end

    assign resp.valid       = out_valid_reg;
    assign resp.pred_target = target_reg;
    assign resp.pred_taken  = taken_reg;

endmodule

/* bench/tb_bounded_two_level_branch_predictor.sv */
`timescale 1ns / 1ps

module tb_bounded_two_level_branch_predictor;

    localparam int ENTRIES      = 128;
    localparam int HIST_W       = 2;
    localparam int PATTERNS     = 1 << HIST_W;
    localparam int POOL         = 192;     // more branch addresses than table slots
    localparam int HOT          = 24;      // small working set that gets trained hard
    localparam int TARGET_COUNT = 1900;
    localparam int IDLE_PCT     = 21;
    localparam int QUIET_FROM   = 800;     // no idling on either side in this window
    localparam int QUIET_TO     = 1400;
    localparam int HOLD_AT      = 1800;    // receiver holds off here for a long stretch
    localparam int HOLD_LEN     = 400;
    localparam int TAIL_CYCLES  = 8;
    localparam int LIMIT        = 200000;

    typedef struct {
        logic        cmd;
        logic [31:0] pc;
        logic [31:0] pc_next;
        logic        is_branch;
        bit          drain_first;   // wait for all predictions before sending
    } request_t;

    typedef struct {
        logic [31:0] pred_target;
        logic        pred_taken;
    } prediction_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    btlbp_req_if  req_ch ();
    btlbp_resp_if resp_ch ();

    bounded_two_level_branch_predictor #(
        .ENTRIES      (ENTRIES),
        .HISTORY_BITS (HIST_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .resp  (resp_ch)
    );

    // 20 ns period
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Shadow copy of the branch table
    logic              slot_used [ENTRIES];
    logic [31:0]       slot_pc   [ENTRIES];
    logic [31:0]       slot_dest [ENTRIES];
    logic [HIST_W-1:0] slot_hist [ENTRIES];
    logic [1:0]        slot_ctr  [ENTRIES][PATTERNS];
    int                alloc_ptr;

    request_t    pending_requests [$];
    prediction_t predictions_due [$];
    request_t    on_bus;
    bit          next_drains;

    int cyc;
    int hold_left;
    int mismatches;
    int n_predicts, n_updates, n_taken_seen, n_allocs, n_evictions, n_random;

    function automatic bit quiet_window();
        return cyc >= QUIET_FROM && cyc < QUIET_TO;
    endfunction

    function automatic bit roll_idle();
        return !quiet_window() && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // Advance the shadow table by one accepted request; queue the answer of a predict.
    function automatic void predict_and_train(input request_t r);
        int                hit_slot;
        logic [HIST_W-1:0] h;
        logic              taken;
        prediction_t       p;
        hit_slot = -1;
        // lowest matching slot; tags stay unique, so at most one slot matches
        for (int i = ENTRIES - 1; i >= 0; i--)
            if (slot_used[i] && slot_pc[i] == r.pc)
                hit_slot = i;
        if (r.cmd == btlbp_pkg::CMD_PREDICT)
        begin
            p.pred_target = '0;
            if (hit_slot >= 0
                && slot_ctr[hit_slot][slot_hist[hit_slot]] >= btlbp_pkg::CTR_STRONG)
                p.pred_target = slot_dest[hit_slot];
            p.pred_taken = (p.pred_target != '0);
            if (p.pred_taken)
                n_taken_seen++;
            predictions_due = {predictions_due, p};
            n_predicts++;
        end
        else if (r.is_branch)
        begin
            n_updates++;
            taken = ((r.pc_next - r.pc) != btlbp_pkg::FALL_THROUGH);
            if (hit_slot < 0)
            begin
                // take the victim slot, evicting whatever sits there
                hit_slot = alloc_ptr;
                if (slot_used[hit_slot])
                    n_evictions++;
                n_allocs++;
                slot_used[hit_slot] = 1'b1;
                slot_pc[hit_slot]   = r.pc;
                slot_hist[hit_slot] = '0;
                for (int j = 0; j < PATTERNS; j++)
                    slot_ctr[hit_slot][j] = btlbp_pkg::CTR_MIN;
                alloc_ptr = (alloc_ptr + 1) % ENTRIES;
            end
            slot_dest[hit_slot] = r.pc_next;
            h = slot_hist[hit_slot];
            if (taken && slot_ctr[hit_slot][h] != btlbp_pkg::CTR_MAX)
                slot_ctr[hit_slot][h] = slot_ctr[hit_slot][h] + 2'd1;
            else if (!taken && slot_ctr[hit_slot][h] != btlbp_pkg::CTR_MIN)
                slot_ctr[hit_slot][h] = slot_ctr[hit_slot][h] - 2'd1;
            slot_hist[hit_slot] = (h << 1) | HIST_W'(taken);
        end
    endfunction

    function automatic void push_predict(input logic [31:0] pc);
        request_t r;
        r.cmd         = btlbp_pkg::CMD_PREDICT;
        r.pc          = pc;
        r.pc_next     = $urandom();   // ignored for a predict, wiggle it anyway
        r.is_branch   = 1'($urandom_range(0, 1));
        r.drain_first = next_drains;
        next_drains   = 1'b0;
        pending_requests = {pending_requests, r};
    endfunction

    function automatic void push_update(input logic [31:0] pc, input logic [31:0] nxt,
                                        input logic br);
        request_t r;
        r.cmd         = btlbp_pkg::CMD_UPDATE;
        r.pc          = pc;
        r.pc_next     = nxt;
        r.is_branch   = br;
        r.drain_first = next_drains;
        next_drains   = 1'b0;
        pending_requests = {pending_requests, r};
    endfunction

    // Request driver: present the next pending request whenever the bus is free,
    // idle at random, and hold a marked request until all predictions are back.
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        bit load;
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.cmd       <= btlbp_pkg::CMD_PREDICT;
            req_ch.pc        <= '0;
            req_ch.pc_next   <= '0;
            req_ch.is_branch <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                predict_and_train(on_bus);
            if (!req_ch.valid || req_ch.ready)
            begin
                load = (pending_requests.size() != 0) && !roll_idle();
                if (load && pending_requests[0].drain_first && predictions_due.size() != 0)
                    load = 1'b0;
                if (load)
                begin
                    on_bus = pending_requests.pop_front();
                    req_ch.cmd       <= on_bus.cmd;
                    req_ch.pc        <= on_bus.pc;
                    req_ch.pc_next   <= on_bus.pc_next;
                    req_ch.is_branch <= on_bus.is_branch;
                end
                req_ch.valid <= load;
            end
        end
    end

    // Long receiver hold-off, counted on its own so the driver keeps pushing
    // and the block backs up into its input.
    always @(posedge clk or negedge rst_n)
    begin : hold_off
        if (!rst_n)
            hold_left <= 0;
        else if (cyc == HOLD_AT)
            hold_left <= HOLD_LEN;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Response checker: compare each accepted prediction with the oldest one due.
    always @(posedge clk or negedge rst_n)
    begin : check_responses
        prediction_t want;
        if (!rst_n)
            resp_ch.ready <= 1'b0;
        else
        begin
            if (resp_ch.valid && resp_ch.ready)
            begin
                if (predictions_due.size() == 0)
                begin
                    $error("unexpected response: pred_target=%h pred_taken=%b",
                           resp_ch.pred_target, resp_ch.pred_taken);
                    mismatches++;
                end
                else
                begin
                    want = predictions_due.pop_front();
                    if (resp_ch.pred_target !== want.pred_target)
                    begin
                        $error("pred_target: expected %h, got %h",
                               want.pred_target, resp_ch.pred_target);
                        mismatches++;
                    end
                    if (resp_ch.pred_taken !== want.pred_taken)
                    begin
                        $error("pred_taken: expected %b, got %b",
                               want.pred_taken, resp_ch.pred_taken);
                        mismatches++;
                    end
                end
            end
            resp_ch.ready <= (hold_left == 0) && !roll_idle();
        end
    end

    // Cycle count and watchdog
    always @(posedge clk)
    begin : watchdog
        cyc <= cyc + 1;
        if (cyc == LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] pool_pc   [POOL];
        logic [31:0] pool_dest [POOL];
        int          pool_bias [POOL];
        int          idx, burst, kind;
        logic [31:0] pc;
        bit          tk;

        cyc         = 0;
        mismatches  = 0;
        alloc_ptr   = 0;
        next_drains = 1'b0;
        n_predicts  = 0;
        n_updates   = 0;
        n_taken_seen = 0;
        n_allocs    = 0;
        n_evictions = 0;
        n_random    = 0;
        for (int i = 0; i < ENTRIES; i++)
            slot_used[i] = 1'b0;
        // hold every input at a known value until reset releases the driver
        req_ch.valid     = 1'b0;
        req_ch.cmd       = btlbp_pkg::CMD_PREDICT;
        req_ch.pc        = '0;
        req_ch.pc_next   = '0;
        req_ch.is_branch = 1'b0;
        resp_ch.ready    = 1'b0;

        // Directed part: misses at both address extremes, a non-branch update,
        // the fall-through distance across the address wrap, a confident entry
        // with a zero target, and training up to a taken prediction.
        push_predict(32'h0000_0000);
        push_predict(32'hFFFF_FFFF);
        push_update(32'h0000_0100, 32'h0000_0200, 1'b0);
        push_predict(32'h0000_0100);
        push_update(32'h0000_0100, 32'h0000_0104, 1'b1);
        push_predict(32'h0000_0100);
        for (int i = 0; i < 5; i++)
            push_update(32'h0000_0100, 32'h0000_0800, 1'b1);
        push_predict(32'h0000_0100);
        push_update(32'hFFFF_FFFC, 32'h0000_0000, 1'b1);
        push_predict(32'hFFFF_FFFC);
        for (int i = 0; i < 4; i++)
            push_update(32'h0000_0040, 32'h0000_0000, 1'b1);
        push_predict(32'h0000_0040);
        for (int i = 0; i < 3; i++)
            push_update(32'hFFFF_FFFF, 32'h0000_0003, 1'b1);
        push_predict(32'hFFFF_FFFF);
        push_update(32'h0000_0008, 32'h0000_0004, 1'b1);
        push_predict(32'h0000_0008);

        // Branch population: random addresses and targets, each with its own
        // taken bias so counters see every pattern from saturating low to high.
        for (int i = 0; i < POOL; i++)
        begin
            pool_pc[i]   = $urandom();
            pool_dest[i] = ($urandom_range(0, 19) == 0) ? 32'h0 : $urandom();
            case (i % 4)
                0: pool_bias[i] = 90;
                1: pool_bias[i] = 50;
                2: pool_bias[i] = 10;
                default: pool_bias[i] = 75;
            endcase
        end

        // Random part: mostly training bursts on one branch followed by a lookup
        // of it, with stray lookups and noise updates mixed in.
        while (n_random < TARGET_COUNT)
        begin
            if (n_random == 700 || n_random == 1400)
                next_drains = 1'b1;
            idx  = ($urandom_range(0, 99) < 75) ? $urandom_range(0, HOT - 1)
                                                : $urandom_range(0, POOL - 1);
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                burst = $urandom_range(1, 4);
                for (int k = 0; k < burst; k++)
                begin
                    tk = ($urandom_range(0, 99) < pool_bias[idx]);
                    push_update(pool_pc[idx],
                                tk ? pool_dest[idx] : pool_pc[idx] + btlbp_pkg::FALL_THROUGH,
                                1'b1);
                end
                push_predict(pool_pc[idx]);
                n_random += burst + 1;
            end
            else if (kind < 90)
            begin
                pc = ($urandom_range(0, 3) == 0) ? $urandom() : pool_pc[idx];
                push_predict(pc);
                n_random++;
            end
            else
            begin
                tk = 1'($urandom_range(0, 1));
                push_update(pool_pc[idx], $urandom(), tk);
                if (tk)
                    n_random++;
            end
        end

        // Release reset
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: every request sent, every prediction back, then a short tail
        while (pending_requests.size() != 0 || req_ch.valid || predictions_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d lookups (%0d predicted taken) and %0d training updates.",
                 n_predicts, n_taken_seen, n_updates);
        $display("Table saw %0d allocations, %0d of them evicting a live branch.",
                 n_allocs, n_evictions);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
